// ===== rtl/packbits_style_rle_encoder_core_assert.svh =====
// Assertion macros shared by the encoder's checker.
`ifndef PACKBITS_STYLE_RLE_ENCODER_CORE_ASSERT_SVH
`define PACKBITS_STYLE_RLE_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PBRLE_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define PBRLE_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pbrle_pkg.sv =====
// Types and constants shared by the run-length encoder modules.
`default_nettype none
package pbrle_pkg;

  // Raw input item.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_last;
  } raw_item_t;

  // One packed output word of up to four encoded bytes.
  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [7:0] third_byte;
    logic [7:0] fourth_byte;
    logic [2:0] byte_count;
    logic       burst_end;
    logic       stream_end;
  } enc_word_t;

  // Header bit that marks a run packet.
  localparam logic [7:0] RUN_FLAG = 8'h80;

  // Source of a generated byte.
  typedef enum logic [1:0] {
    GEN_HDR,
    GEN_MEM,
    GEN_TAIL
  } gen_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      accept;
    logic      sel_b;
    logic      issue;
    gen_kind_t kind;
    logic      burst_last;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic new_a;
    logic new_b;
    logic b_valid;
    logic gen_ready;
    logic body_empty;
    logic body_last;
    logic has_tail;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/pbrle_ctrl.sv =====
// Controller state machine that sequences the bytes of up to two packets per input.
`default_nettype none
module pbrle_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               raw_valid,
  output logic                    raw_ready,
  input  wire pbrle_pkg::dp_stat_t stat,
  output pbrle_pkg::ctl_cmd_t     cmd
);
  import pbrle_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_HDR  = 4'b0010,
    ST_BODY = 4'b0100,
    ST_TAIL = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   pkt_b, pkt_b_next;
  logic   pkt_end;

  assign raw_ready = (state == ST_IDLE);

  always_comb begin
    state_next     = state;
    pkt_b_next     = pkt_b;
    pkt_end        = 1'b0;
    cmd.accept     = 1'b0;
    cmd.sel_b      = pkt_b;
    cmd.issue      = 1'b0;
    cmd.kind       = GEN_HDR;
    cmd.burst_last = 1'b0;
    case (state)
      ST_IDLE: begin
        if (raw_valid) begin
          cmd.accept = 1'b1;
          if (stat.new_a) begin
            state_next = ST_HDR;
            pkt_b_next = 1'b0;
          end else if (stat.new_b) begin
            state_next = ST_HDR;
            pkt_b_next = 1'b1;
          end
        end
      end
      ST_HDR: begin
        if (stat.gen_ready) begin
          cmd.issue = 1'b1;
          cmd.kind  = GEN_HDR;
          if (!stat.body_empty) begin
            state_next = ST_BODY;
          end else if (stat.has_tail) begin
            state_next = ST_TAIL;
          end else begin
            pkt_end = 1'b1;
          end
        end
      end
      ST_BODY: begin
        if (stat.gen_ready) begin
          cmd.issue = 1'b1;
          cmd.kind  = GEN_MEM;
          if (stat.body_last) begin
            if (stat.has_tail) begin
              state_next = ST_TAIL;
            end else begin
              pkt_end = 1'b1;
            end
          end
        end
      end
      ST_TAIL: begin
        if (stat.gen_ready) begin
          cmd.issue = 1'b1;
          cmd.kind  = GEN_TAIL;
          pkt_end   = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // After the last byte of a packet, either move on to the flush packet
    // or close the burst.
    if (pkt_end) begin
      if (!pkt_b && stat.b_valid) begin
        state_next = ST_HDR;
        pkt_b_next = 1'b1;
      end else begin
        state_next     = ST_IDLE;
        cmd.burst_last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pkt_b <= 1'b0;
    end else begin
      state <= state_next;
      pkt_b <= pkt_b_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pbrle_dp.sv =====
// Datapath: encoder state, literal memory, byte generation and word packing.
`default_nettype none
module pbrle_dp #(
  parameter int MAX_PACKET = 128
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire pbrle_pkg::raw_item_t raw_data,
  input  wire pbrle_pkg::ctl_cmd_t  cmd,
  output pbrle_pkg::dp_stat_t       stat,
  output logic                      enc_valid,
  input  wire logic                 enc_ready,
  output pbrle_pkg::enc_word_t      enc_data
);
  import pbrle_pkg::*;

  localparam int CW = $clog2(MAX_PACKET);
  localparam logic [CW-1:0] CNT_FULL = CW'(MAX_PACKET - 1);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);

  // Encoder state.
  logic [7:0]    pend;
  logic          have;
  logic          run;
  logic [CW-1:0] cnt;

  // Literal bytes, written before they are read.
  logic [7:0] mem [MAX_PACKET];
  logic [7:0] mem_q;

  // Packet descriptors: A is the packet emitted along the way, B the flush on stream end.
  logic          b_valid;
  logic [7:0]    a_hdr, b_hdr;
  logic [CW-1:0] a_m, b_m;
  logic          a_ten, b_ten;
  logic [7:0]    a_tail, b_tail;
  logic          burst_stream;

  // Next values computed from the incoming byte.
  logic          na_v;
  logic [7:0]    na_hdr;
  logic [CW-1:0] na_m;
  logic          na_ten;
  logic [7:0]    na_tail;
  logic [7:0]    nb_hdr;
  logic [CW-1:0] nb_m;
  logic [7:0]    nb_tail;
  logic [7:0]    pend_next;
  logic          have_next;
  logic          run_next;
  logic [CW-1:0] cnt_next;
  logic          wr_en;
  logic          full;
  logic [CW-1:0] cnt_inc;

  assign full    = have && (cnt == CNT_FULL);
  assign cnt_inc = cnt + CNT_ONE;

  always_comb begin
    na_v      = 1'b0;
    na_hdr    = 8'(cnt);
    na_m      = '0;
    na_ten    = 1'b1;
    na_tail   = pend;
    pend_next = raw_data.in_byte;
    have_next = 1'b1;
    run_next  = 1'b0;
    cnt_next  = '0;
    wr_en     = 1'b0;
    if (!have) begin
      // First byte of a stream only gets held.
    end else if (full) begin
      na_v   = 1'b1;
      na_hdr = run ? (RUN_FLAG | 8'(cnt)) : 8'(cnt);
      na_m   = run ? '0 : cnt;
    end else if (raw_data.in_byte == pend) begin
      na_v      = !run && (cnt != '0);
      na_hdr    = 8'(cnt - CNT_ONE);
      na_m      = cnt;
      na_ten    = 1'b0;
      pend_next = pend;
      run_next  = 1'b1;
      cnt_next  = run ? cnt_inc : CNT_ONE;
    end else if (run) begin
      na_v   = 1'b1;
      na_hdr = RUN_FLAG | 8'(cnt);
    end else begin
      wr_en    = 1'b1;
      cnt_next = cnt_inc;
    end

    // Flush packet built from the state left after this byte.
    nb_hdr  = run_next ? (RUN_FLAG | 8'(cnt_next)) : 8'(cnt_next);
    nb_m    = run_next ? '0 : cnt_next;
    nb_tail = pend_next;

    if (raw_data.stream_last) begin
      pend_next = '0;
      have_next = 1'b0;
      run_next  = 1'b0;
      cnt_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend    <= '0;
      have    <= 1'b0;
      run     <= 1'b0;
      cnt     <= '0;
      b_valid <= 1'b0;
    end else if (cmd.accept) begin
      pend    <= pend_next;
      have    <= have_next;
      run     <= run_next;
      cnt     <= cnt_next;
      b_valid <= raw_data.stream_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      a_hdr        <= na_hdr;
      a_m          <= na_m;
      a_ten        <= na_ten;
      a_tail       <= na_tail;
      b_hdr        <= nb_hdr;
      b_m          <= nb_m;
      b_ten        <= 1'b1;
      b_tail       <= nb_tail;
      burst_stream <= raw_data.stream_last;
    end
  end

  // Selected packet and body index.
  logic [CW-1:0] idx;
  logic [CW-1:0] sel_m;
  logic [7:0]    sel_hdr, sel_tail;
  logic          adv;

  assign sel_m    = cmd.sel_b ? b_m : a_m;
  assign sel_hdr  = cmd.sel_b ? b_hdr : a_hdr;
  assign sel_tail = cmd.sel_b ? b_tail : a_tail;

  assign stat.new_a      = na_v;
  assign stat.new_b      = raw_data.stream_last;
  assign stat.b_valid    = b_valid;
  assign stat.gen_ready  = adv;
  assign stat.body_empty = (sel_m == '0);
  assign stat.body_last  = (idx == (sel_m - CNT_ONE));
  assign stat.has_tail   = cmd.sel_b ? b_ten : a_ten;

  // Memory write on accept, registered read when a body byte is issued.
  always_ff @(posedge clk) begin
    if (cmd.accept && wr_en) begin
      mem[cnt] <= pend;
    end
    if (adv && cmd.issue && (cmd.kind == GEN_MEM)) begin
      mem_q <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && cmd.issue) begin
      if (cmd.kind == GEN_HDR) begin
        idx <= '0;
      end else if (cmd.kind == GEN_MEM) begin
        idx <= idx + CNT_ONE;
      end
    end
  end

  // Generated byte stage.
  logic       s1_valid;
  logic       s1_mem;
  logic [7:0] s1_const;
  logic       s1_last;
  logic       s1_stream;
  logic [7:0] cur_byte;

  assign cur_byte = s1_mem ? mem_q : s1_const;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mem    <= (cmd.kind == GEN_MEM);
      s1_const  <= (cmd.kind == GEN_HDR) ? sel_hdr : sel_tail;
      s1_last   <= cmd.burst_last;
      s1_stream <= burst_stream;
    end
  end

  // Word packer.
  logic [7:0] acc [3];
  logic [1:0] acc_cnt;
  logic       push;
  logic       pack_go;
  logic       out_free;
  enc_word_t  word;

  assign out_free = !enc_valid || enc_ready;
  assign push     = s1_valid && ((acc_cnt == 2'd3) || s1_last);
  assign pack_go  = s1_valid && (!push || out_free);
  assign adv      = !s1_valid || pack_go;

  always_comb begin
    word.first_byte  = (acc_cnt == 2'd0) ? cur_byte : acc[0];
    word.second_byte = (acc_cnt > 2'd1) ? acc[1] : ((acc_cnt == 2'd1) ? cur_byte : 8'd0);
    word.third_byte  = (acc_cnt > 2'd2) ? acc[2] : ((acc_cnt == 2'd2) ? cur_byte : 8'd0);
    word.fourth_byte = (acc_cnt == 2'd3) ? cur_byte : 8'd0;
    word.byte_count  = 3'(acc_cnt) + 3'd1;
    word.burst_end   = s1_last;
    word.stream_end  = s1_last && s1_stream;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_cnt   <= '0;
      enc_valid <= 1'b0;
    end else begin
      if (pack_go) begin
        acc_cnt <= push ? 2'd0 : acc_cnt + 2'd1;
      end
      if (pack_go && push) begin
        enc_valid <= 1'b1;
      end else if (enc_ready) begin
        enc_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pack_go && !push) begin
      acc[acc_cnt] <= cur_byte;
    end
    if (pack_go && push) begin
      enc_data <= word;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/packbits_style_rle_encoder_core.sv =====
// PackBits-style run-length encoder: top level joining controller and datapath.
//
// Usage: raw bytes arrive on the raw channel (raw_valid/raw_ready/raw_data), each
// with a stream_last flag. Encoded output leaves on the enc channel as words of
// one to four bytes, packed in stream order; every transfer follows valid/ready.
// A run packet is a header 0x80|(count-1) and the repeated byte; a literal packet
// is a header (count-1) and its bytes. Packets never exceed MAX_PACKET bytes.
// A byte that only extends a packet leaves raw_ready high. A byte that closes one
// or two packets holds raw_ready low while their encoded bytes are generated; the
// generator emits one byte per cycle while the packer can take it (one memory
// read per literal byte). burst_end marks the last word of each burst and
// stream_end the last word of the stream.
// The output register decouples the sides: a new byte is taken while the last
// word of a burst still waits. If the receiver stalls, words hold steady and
// the generator pauses, so nothing is lost.
// Reset clears the encoder state; the next byte starts a new stream. After a
// stream_last byte the encoder returns to that same state by itself.
`default_nettype none
module packbits_style_rle_encoder_core #(
  parameter int MAX_PACKET = 128
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 raw_valid,
  output logic                      raw_ready,
  input  wire pbrle_pkg::raw_item_t raw_data,
  output logic                      enc_valid,
  input  wire logic                 enc_ready,
  output pbrle_pkg::enc_word_t      enc_data
);
  import pbrle_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // The controller walks header, literal body and trailing byte of each packet.
  pbrle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .raw_valid (raw_valid),
    .raw_ready (raw_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath keeps the encoder state, the literal memory and the packer.
  pbrle_dp #(
    .MAX_PACKET (MAX_PACKET)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .raw_data  (raw_data),
    .cmd       (cmd),
    .stat      (stat),
    .enc_valid (enc_valid),
    .enc_ready (enc_ready),
    .enc_data  (enc_data)
  );

endmodule
`default_nettype wire

// ===== rtl/pbrle_checker.sv =====
// Port-level checker for the encoder, bound to the top level.
`default_nettype none
`include "packbits_style_rle_encoder_core_assert.svh"
module pbrle_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 enc_valid,
  input wire logic                 enc_ready,
  input wire pbrle_pkg::enc_word_t enc_data
);
  import pbrle_pkg::*;

  logic count_ok;

  assign count_ok = (enc_data.byte_count != 3'd0) && (enc_data.byte_count <= 3'd4);

  `PBRLE_NEXT(a_hold, enc_valid && !enc_ready, enc_valid && $stable(enc_data), "word dropped")
  `PBRLE_HOLDS(a_count, enc_valid, count_ok, "bad count")
  `PBRLE_HOLDS(a_partial, enc_valid && enc_data.byte_count != 3'd4, enc_data.burst_end, "short word")
  `PBRLE_HOLDS(a_stream, enc_valid && enc_data.stream_end, enc_data.burst_end, "stream end")

endmodule

bind packbits_style_rle_encoder_core pbrle_checker u_chk (.*);
`default_nettype wire
